@@ design/dem_pkg.sv @@
// shared types and constants for the decimal-exponent modular power block
// no dependencies; used by dem_recip, dem_modmul and decimal_exponent_modpow
package dem_pkg;

  localparam int unsigned MOD_W   = 16;
  localparam int unsigned BASE_W  = 31;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned MU_W    = 32;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 16'd1337;
  localparam logic [MOD_W-1:0] MODULUS_MIN   = 16'd2;

  // floor(2^32 / reset modulus), so no reciprocal pass is needed out of reset
  localparam logic [MU_W-1:0] MU_RESET =
    32'((64'd1 << MU_W) / 64'(MODULUS_RESET));

  // request to the shared modular multiplier
  typedef struct packed {
    logic              start;
    logic [BASE_W-1:0] a;
    logic [MOD_W-1:0]  b;
  } mm_req_t;

  // response from the shared modular multiplier
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] res;
  } mm_rsp_t;

endpackage

@@ design/dem_recip.sv @@
// radix-2 restoring divider producing the reduction constant floor(2^32 / m)
// depends on dem_pkg
module dem_recip import dem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_i,
  input  logic [MOD_W-1:0] m_i,
  output logic [MU_W-1:0]  mu_o,
  output logic             busy_o
);

  localparam logic [5:0] CNT_TOP = 6'(MU_W);

  logic [MOD_W-1:0] rem_r;
  logic [MU_W-1:0]  mu_r;
  logic [5:0]       cnt_r;
  logic             busy_r;

  logic [MOD_W:0]   rem_sh;
  logic             ge;
  logic [MOD_W:0]   rem_nxt;

  // dividend is a single one at bit 32 followed by zeros
  assign rem_sh  = {rem_r, (cnt_r == CNT_TOP)};
  assign ge      = (rem_sh >= {1'b0, m_i});
  assign rem_nxt = ge ? (rem_sh - {1'b0, m_i}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mu_r   <= MU_RESET;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else if (load_i) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_TOP;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt[MOD_W-1:0];
      mu_r  <= {mu_r[MU_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  assign mu_o   = mu_r;
  assign busy_o = busy_r;

endmodule

@@ design/dem_modmul.sv @@
// shared modular multiplier: one 32x32 multiplier reused for the product and
// both barrett steps, then one conditional subtract; depends on dem_pkg
module dem_modmul import dem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  mm_req_t          req_i,
  input  logic [MOD_W-1:0] m_i,
  input  logic [MU_W-1:0]  mu_i,
  output mm_rsp_t          rsp_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_QUO,
    PH_QM,
    PH_SUB,
    PH_FIX
  } phase_t;

  phase_t          phase_r;
  logic [31:0]     x_r;
  logic [31:0]     q_r;
  logic [31:0]     qm_r;
  logic [MOD_W:0]  r_r;

  logic [31:0]     op_a;
  logic [31:0]     op_b;
  logic [63:0]     prod;
  logic [MOD_W:0]  r_fix;

  always_comb begin
    case (phase_r)
      PH_IDLE: begin
        op_a = 32'(req_i.a);
        op_b = 32'(req_i.b);
      end
      PH_QUO: begin
        op_a = x_r;
        op_b = mu_i;
      end
      PH_QM: begin
        op_a = q_r;
        op_b = 32'(m_i);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = 64'(op_a) * 64'(op_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (req_i.start) begin
            x_r     <= prod[31:0];
            phase_r <= PH_QUO;
          end
        end
        PH_QUO: begin
          q_r     <= prod[63:32];
          phase_r <= PH_QM;
        end
        PH_QM: begin
          qm_r    <= prod[31:0];
          phase_r <= PH_SUB;
        end
        PH_SUB: begin
          // barrett estimate is low by at most one, so the rest is below 2m
          r_r     <= 17'(x_r - qm_r);
          phase_r <= PH_FIX;
        end
        PH_FIX: begin
          phase_r <= PH_IDLE;
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  assign r_fix     = (r_r >= {1'b0, m_i}) ? (r_r - {1'b0, m_i}) : r_r;
  assign rsp_o.done = (phase_r == PH_FIX);
  assign rsp_o.res  = r_fix[MOD_W-1:0];

endmodule

@@ design/decimal_exponent_modpow.sv @@
// top level: base^E mod m with E streamed as decimal digits, msd first
// depends on dem_pkg, dem_recip (reduction constant) and dem_modmul (shared unit)
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+----------------------
//  in      | in_base[30:0] in_digit[3:0] in_last    | in_valid / in_stall
//  out     | out_residue[15:0]                      | out_valid / out_stall
//  cfg     | cfg_modulus[15:0]                      | cfg_valid / cfg_ready
//
// one digit beat runs up to 13 modular products one after another on the single
// multiplier in dem_modmul, plus the walk over the digit bits and sequencing;
// modulus 0 or 1 skips the products and gives zero.
// after a modulus write dem_recip builds the new reciprocal and
// in_stall stays high meanwhile; out of reset the reciprocal of 1337 is ready.
// a last beat waits for the output register to free up before it finishes.
module decimal_exponent_modpow import dem_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // digit stream
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BASE_W-1:0]  in_base,
  input  logic [DIGIT_W-1:0] in_digit,
  input  logic               in_last,
  // result stream
  output logic               out_valid,
  input  logic               out_stall,
  output logic [MOD_W-1:0]   out_residue,
  // modulus register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [MOD_W-1:0]   cfg_modulus
);

  // sequencer: each wait state names the product it is waiting for
  typedef enum logic [3:0] {
    S_IDLE,
    S_RR,     // running residue mod m
    S_BR,     // base mod m
    S_R2,
    S_R4,
    S_R5,
    S_R10,    // r^10 by square, square, multiply, square
    S_DIG,    // walk the digit bits msb first
    S_DSQ,
    S_DMUL,
    S_FIN0,
    S_FIN,    // r^10 * base^d
    S_DONE
  } state_t;

  state_t               state_r;
  logic [MOD_W-1:0]     modulus_r;
  logic [MOD_W-1:0]     running_r;
  logic [BASE_W-1:0]    base_r;
  logic [DIGIT_W-1:0]   digit_r;
  logic                 last_r;
  logic [MOD_W-1:0]     rr_r;
  logic [MOD_W-1:0]     br_r;
  logic [MOD_W-1:0]     t_r;
  logic [MOD_W-1:0]     p_r;
  logic                 one_r;     // p still holds the implicit one
  logic                 sqd_r;     // square for the current bit already done
  logic [1:0]           bit_r;
  logic [MOD_W-1:0]     res_r;
  mm_req_t              req_r;
  logic                 out_valid_r;
  logic [MOD_W-1:0]     out_residue_r;

  mm_rsp_t              rsp;
  logic [MU_W-1:0]      mu;
  logic                 recip_busy;
  logic                 in_accept;
  logic                 cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // no new digit while a digit is in flight or the reciprocal is rebuilt
  assign in_stall  = (state_r != S_IDLE) || recip_busy;
  assign in_accept = in_valid && !in_stall;

  dem_recip u_recip (
    .clk    (clk),
    .rst_n  (rst_n),
    .load_i (cfg_write),
    .m_i    (modulus_r),
    .mu_o   (mu),
    .busy_o (recip_busy)
  );

  dem_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (req_r),
    .m_i   (modulus_r),
    .mu_i  (mu),
    .rsp_o (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modulus_r   <= MODULUS_RESET;
      running_r   <= 16'd1;
      req_r.start <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a last beat in S_DONE owns the output register this cycle
      if (out_valid_r && !out_stall && !((state_r == S_DONE) && last_r)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_write) begin
        modulus_r <= cfg_modulus;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            base_r  <= in_base;
            digit_r <= in_digit;
            last_r  <= in_last;
            if (modulus_r < MODULUS_MIN) begin
              // degenerate modulus: everything collapses to zero
              req_r.start <= 1'b0;
              res_r       <= '0;
              state_r     <= S_DONE;
            end else begin
              // reduce the running value first, the modulus may have moved
              req_r.start <= 1'b1;
              req_r.a     <= 31'(running_r);
              req_r.b     <= 16'd1;
              state_r     <= S_RR;
            end
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_RR: begin
          if (rsp.done) begin
            rr_r        <= rsp.res;
            req_r.start <= 1'b1;
            req_r.a     <= base_r;
            req_r.b     <= 16'd1;
            state_r     <= S_BR;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_BR: begin
          if (rsp.done) begin
            br_r        <= rsp.res;
            req_r.start <= 1'b1;
            req_r.a     <= 31'(rr_r);
            req_r.b     <= rr_r;
            state_r     <= S_R2;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_R2: begin
          if (rsp.done) begin
            req_r.start <= 1'b1;
            req_r.a     <= 31'(rsp.res);
            req_r.b     <= rsp.res;
            state_r     <= S_R4;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_R4: begin
          if (rsp.done) begin
            req_r.start <= 1'b1;
            req_r.a     <= 31'(rsp.res);
            req_r.b     <= rr_r;
            state_r     <= S_R5;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_R5: begin
          if (rsp.done) begin
            req_r.start <= 1'b1;
            req_r.a     <= 31'(rsp.res);
            req_r.b     <= rsp.res;
            state_r     <= S_R10;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_R10: begin
          req_r.start <= 1'b0;
          if (rsp.done) begin
            t_r     <= rsp.res;
            one_r   <= 1'b1;
            sqd_r   <= 1'b0;
            bit_r   <= 2'(DIGIT_W - 1);
            state_r <= S_DIG;
          end
        end
        S_DIG: begin
          // square and multiply for base^digit, skipping work on the leading one
          if (!one_r && !sqd_r) begin
            req_r.start <= 1'b1;
            req_r.a     <= 31'(p_r);
            req_r.b     <= p_r;
            state_r     <= S_DSQ;
          end else if (digit_r[bit_r] && !one_r) begin
            req_r.start <= 1'b1;
            req_r.a     <= 31'(p_r);
            req_r.b     <= br_r;
            state_r     <= S_DMUL;
          end else begin
            req_r.start <= 1'b0;
            if (digit_r[bit_r]) begin
              p_r   <= br_r;
              one_r <= 1'b0;
            end
            if (bit_r == 2'd0) begin
              state_r <= S_FIN0;
            end else begin
              bit_r <= bit_r - 2'd1;
              sqd_r <= 1'b0;
            end
          end
        end
        S_DSQ: begin
          req_r.start <= 1'b0;
          if (rsp.done) begin
            p_r     <= rsp.res;
            sqd_r   <= 1'b1;
            state_r <= S_DIG;
          end
        end
        S_DMUL: begin
          req_r.start <= 1'b0;
          if (rsp.done) begin
            p_r <= rsp.res;
            if (bit_r == 2'd0) begin
              state_r <= S_FIN0;
            end else begin
              bit_r   <= bit_r - 2'd1;
              sqd_r   <= 1'b0;
              state_r <= S_DIG;
            end
          end
        end
        S_FIN0: begin
          if (one_r) begin
            // digit zero: r^10 already reduced, nothing to multiply in
            req_r.start <= 1'b0;
            res_r       <= t_r;
            state_r     <= S_DONE;
          end else begin
            req_r.start <= 1'b1;
            req_r.a     <= 31'(t_r);
            req_r.b     <= p_r;
            state_r     <= S_FIN;
          end
        end
        S_FIN: begin
          req_r.start <= 1'b0;
          if (rsp.done) begin
            res_r   <= rsp.res;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          req_r.start <= 1'b0;
          if (last_r) begin
            // hold until the output register is free
            if (!out_valid_r || !out_stall) begin
              out_valid_r   <= 1'b1;
              out_residue_r <= res_r;
              running_r     <= 16'd1;
              state_r       <= S_IDLE;
            end
          end else begin
            running_r <= res_r;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          req_r.start <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;

endmodule
